// ===== sv/trapezoid_motor_speed_profile_macros.svh =====
// Assertion macros for the trapezoid motor speed profiler.
// Included by files that carry concurrent assertions; needs clock and reset in scope.
`ifndef TRAPEZOID_MOTOR_SPEED_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTOR_SPEED_PROFILE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tmsp_pkg.sv =====
// Shared types and constants for the trapezoid motor speed profiler.
// No dependencies; used by tmsp_div and trapezoid_motor_speed_profile.
package tmsp_pkg;

   localparam int TIME_BITS_DEFAULT = 24;
   localparam int FIELD_TIME_W      = 24;
   localparam int SPEED_CODE_W      = 8;
   localparam int MAG_W             = 7;
   localparam int DUTY_W            = 12;
   localparam int SPEED_W           = 8;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 24;

   localparam logic [SPEED_CODE_W-1:0] SPEED_FWD_MAX = 8'd100;
   localparam logic [SPEED_CODE_W-1:0] SPEED_REV_MAX = 8'd200;
   localparam logic [SPEED_CODE_W-1:0] SPEED_ZERO    = 8'd0;
   localparam logic [DUTY_W-1:0]       DUTY_FULL     = 12'd4000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_CODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_LENGTH = 1'd1;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [FIELD_TIME_W-1:0] move_length;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]         pin1_duty;
      logic [DUTY_W-1:0]         pin2_duty;
      logic [DUTY_W-1:0]         enable_duty;
      logic signed [SPEED_W-1:0] current_speed;
      logic                      move_done;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BOUNDS,
      ST_REGION,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ===== sv/tmsp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tmsp_pkg for the status struct.
module tmsp_div #(
   parameter int DEN_W = 24,
   parameter int Q_W   = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DEN_W+Q_W-1:0]     num,
   input  logic [DEN_W-1:0]         den,
   output tmsp_pkg::div_stat_type   stat,
   output logic [Q_W-1:0]           quotient
);
   import tmsp_pkg::*;

   localparam int N_W  = DEN_W + Q_W;
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [N_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   dsr_ff, dsr_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   // The caller guarantees the quotient fits in Q_W bits.
   assign ge = (rem_ff >= dsr_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsr_in  = N_W'(den) << (Q_W - 1);
         q_in    = '0;
         cnt_in  = CNT_W'(Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsr_ff;
         end
         q_in   = {q_ff[Q_W-2:0], ge};
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

// ===== sv/trapezoid_motor_speed_profile.sv =====
// Trapezoid motor speed profiler: start and tick transactions in, duty results out.
// A ramp tick runs CHECK, BOUNDS, REGION, MUL, DIV and FINISH; a flat tick skips MUL and DIV, an
// ending tick goes from CHECK to FINISH, which waits for a free output slot. Start and idle ticks
// give no result. DIV waits on the 7-step iterative divider in tmsp_div (one quotient bit a cycle).
// Reset (synchronous, active high) clears the sequencer, the move state and both registers.
// Depends on tmsp_pkg, tmsp_div and trapezoid_motor_speed_profile_macros.svh.
`include "trapezoid_motor_speed_profile_macros.svh"

module trapezoid_motor_speed_profile #(
   parameter int TIME_BITS = tmsp_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tmsp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tmsp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [tmsp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmsp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tmsp_pkg::*;

   // Fields arrive at a fixed width; they are masked or zero-extended to TIME_BITS.
   localparam int EXT_W = (TIME_BITS > FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
   localparam int NUM_W = TIME_BITS + MAG_W;

   // Sequencer state.
   state_type state_ff, state_in;

   // Configuration registers.
   logic [SPEED_CODE_W-1:0] speed_code_ff, speed_code_in;
   logic [TIME_BITS-1:0]    ramp_ff, ramp_in;

   // Move state. The target speed is kept as a sign and a magnitude.
   logic                    moving_ff, moving_in;
   logic [TIME_BITS-1:0]    elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]    len_ff, len_in;
   logic                    tgt_neg_ff, tgt_neg_in;
   logic [MAG_W-1:0]        tgt_mag_ff, tgt_mag_in;

   // Per-tick working registers.
   logic                    tri_ff, tri_in;
   logic [TIME_BITS-1:0]    mark_a_ff, mark_a_in;
   logic [TIME_BITS-1:0]    mark_b_ff, mark_b_in;
   logic [TIME_BITS-1:0]    dspan_ff, dspan_in;
   logic                    down_ff, down_in;
   logic [TIME_BITS-1:0]    x_ff, x_in;
   logic [TIME_BITS-1:0]    span_ff, span_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    end_ff, end_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Control and datapath helpers.
   logic                    req_accept;
   logic                    slot_free;
   logic                    rsp_load;
   logic                    div_start;
   logic                    move_over;
   logic                    region_up;
   logic                    region_flat;
   logic [EXT_W-1:0]        len_ext;
   logic [EXT_W-1:0]        ramp_ext;
   logic [TIME_BITS-1:0]    elapsed_inc;
   logic [TIME_BITS-1:0]    half_len;
   logic [NUM_W-1:0]        div_num;
   logic [MAG_W-1:0]        div_q;
   div_stat_type            div_stat;
   logic [DUTY_W-1:0]       duty;
   logic [SPEED_W-1:0]      speed_mag;

   assign req_accept = req_valid && req_ready;
   // A finished result may be loaded when the output register is empty or draining.
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   assign len_ext  = EXT_W'(req_data.move_length);
   assign ramp_ext = EXT_W'(csr_wdata);

   // The elapsed counter saturates at its all-ones value.
   assign elapsed_inc = (elapsed_ff == {TIME_BITS{1'b1}}) ? elapsed_ff
                                                          : elapsed_ff + TIME_BITS'(1);
   assign move_over   = (elapsed_ff >= len_ff);
   assign half_len    = len_ff >> 1;

   // Region of the profile for the current elapsed count. For a triangle both marks
   // sit at half the length, so the flat region is empty.
   assign region_up   = (elapsed_ff < mark_a_ff);
   assign region_flat = !region_up && (elapsed_ff < mark_b_ff);

   // Each ramp value is offset * |target| / span, truncated. The product is
   // registered inside the divider as its starting remainder.
   assign div_num = NUM_W'(x_ff) * NUM_W'(tgt_mag_ff);

   tmsp_div #(
      .DEN_W (TIME_BITS),
      .Q_W   (MAG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (span_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.opcode == OP_TICK) && moving_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = move_over ? ST_FINISH : ST_BOUNDS;
         end
         ST_BOUNDS: begin
            state_in = ST_REGION;
         end
         ST_REGION: begin
            state_in = region_flat ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MUL: begin
            div_start = 1'b1;
         end
         ST_FINISH: begin
            rsp_load = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Configuration writes take effect at the next edge. The ramp length is read on
   // every tick, so a write is expected only while no move is being profiled.
   always_comb begin
      speed_code_in = speed_code_ff;
      ramp_in       = ramp_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPEED_CODE: begin
               speed_code_in = csr_wdata[SPEED_CODE_W-1:0];
            end
            CSR_RAMP_LENGTH: begin
               ramp_in = ramp_ext[TIME_BITS-1:0];
            end
            default: begin
               ramp_in = ramp_ff;
            end
         endcase
      end
   end

   // Datapath.
   always_comb begin
      moving_in  = moving_ff;
      elapsed_in = elapsed_ff;
      len_in     = len_ff;
      tgt_neg_in = tgt_neg_ff;
      tgt_mag_in = tgt_mag_ff;
      tri_in     = tri_ff;
      mark_a_in  = mark_a_ff;
      mark_b_in  = mark_b_ff;
      dspan_in   = dspan_ff;
      down_in    = down_ff;
      x_in       = x_ff;
      span_in    = span_ff;
      mag_in     = mag_ff;
      end_in     = end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.opcode == OP_START) begin
                  // A start restarts the move and decodes the speed code.
                  len_in     = len_ext[TIME_BITS-1:0];
                  elapsed_in = '0;
                  moving_in  = 1'b1;
                  if (speed_code_ff == SPEED_ZERO) begin
                     tgt_neg_in = 1'b0;
                     tgt_mag_in = '0;
                  end else if (speed_code_ff <= SPEED_FWD_MAX) begin
                     tgt_neg_in = 1'b0;
                     tgt_mag_in = speed_code_ff[MAG_W-1:0];
                  end else if (speed_code_ff <= SPEED_REV_MAX) begin
                     tgt_neg_in = 1'b1;
                     tgt_mag_in = MAG_W'(speed_code_ff - SPEED_FWD_MAX);
                  end
               end else if (moving_ff) begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         ST_CHECK: begin
            end_in = move_over;
            mag_in = '0;
            // Triangle when the length is under twice the ramp.
            tri_in = ({1'b0, len_ff} < {ramp_ff, 1'b0});
         end
         ST_BOUNDS: begin
            if (tri_ff) begin
               mark_a_in = half_len;
               mark_b_in = half_len;
               dspan_in  = len_ff - half_len;
            end else begin
               mark_a_in = ramp_ff;
               mark_b_in = len_ff - ramp_ff;
               dspan_in  = ramp_ff;
            end
         end
         ST_REGION: begin
            if (region_up) begin
               down_in = 1'b0;
               x_in    = elapsed_ff;
               span_in = mark_a_ff;
            end else if (region_flat) begin
               mag_in = tgt_mag_ff;
            end else begin
               down_in = 1'b1;
               x_in    = elapsed_ff - mark_b_ff;
               span_in = dspan_ff;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               // Ramping down, the speed falls from the target by the quotient.
               mag_in = down_ff ? (tgt_mag_ff - div_q) : div_q;
            end
         end
         ST_FINISH: begin
            if (slot_free && end_ff) begin
               moving_in = 1'b0;
            end
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   // Duty is the magnitude times 40, built from two shifts.
   assign duty      = DUTY_W'({mag_ff, 5'b0}) + DUTY_W'({mag_ff, 3'b0});
   assign speed_mag = SPEED_W'(mag_ff);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.pin1_duty     = tgt_neg_ff ? duty : '0;
         rsp_data_in.pin2_duty     = tgt_neg_ff ? '0 : duty;
         rsp_data_in.enable_duty   = end_ff ? '0 : DUTY_FULL;
         rsp_data_in.current_speed = tgt_neg_ff ? -$signed(speed_mag) : $signed(speed_mag);
         rsp_data_in.move_done     = end_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         speed_code_ff <= '0;
         ramp_ff       <= '0;
         moving_ff     <= 1'b0;
         elapsed_ff    <= '0;
         len_ff        <= '0;
         tgt_neg_ff    <= 1'b0;
         tgt_mag_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         speed_code_ff <= speed_code_in;
         ramp_ff       <= ramp_in;
         moving_ff     <= moving_in;
         elapsed_ff    <= elapsed_in;
         len_ff        <= len_in;
         tgt_neg_ff    <= tgt_neg_in;
         tgt_mag_ff    <= tgt_mag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tri_ff      <= tri_in;
      mark_a_ff   <= mark_a_in;
      mark_b_ff   <= mark_b_in;
      dspan_ff    <= dspan_in;
      down_ff     <= down_in;
      x_ff        <= x_in;
      span_ff     <= span_in;
      mag_ff      <= mag_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider only reports a result while the sequencer is waiting for it.
   `TMSP_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_ff == ST_DIV, "divider done outside DIV")
   // A profiled speed never exceeds the target magnitude.
   `TMSP_ASSERT_NOW(a_mag_bounded, rsp_load, mag_ff <= tgt_mag_ff, "speed above target")
   // Delivering the ending transaction stops the move.
   `TMSP_ASSERT_NEXT(a_end_stops, rsp_load && end_ff, !moving_ff, "move still running after end")
   // A tick taken during a move always starts the profile sequence.
   `TMSP_ASSERT_NEXT(a_tick_runs, req_accept && moving_ff && (req_data.opcode == OP_TICK), state_ff == ST_CHECK, "tick not processed")

endmodule
